FILE: hdl/bet_pkg.sv
// ----------------------------------------------------------------------------
// bet_pkg
// Shared widths, constants, request types and the sequencer states of the
// binomial expansion block.
// ----------------------------------------------------------------------------
package bet_pkg;

    localparam int BASE_W   = 16;
    localparam int EXP_W    = 6;
    localparam int VALUE_W  = 64;
    localparam int FACT_W   = 16;
    localparam int PROD_W   = VALUE_W + FACT_W;
    localparam int DIVD_W   = 70;
    localparam int DVSR_W   = EXP_W + 1;
    localparam int MCNT_W   = $clog2(FACT_W + 1);
    localparam int DCNT_W   = $clog2(DIVD_W + 1);

    localparam logic [EXP_W-1:0]   MAX_EXPONENT = 6'd63;
    localparam logic [VALUE_W-1:0] TWO_POW_63   = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] mcand;
        logic [FACT_W-1:0]  mplier;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FA,
        ST_WA,
        ST_FB,
        ST_WB,
        ST_EMIT,
        ST_CM,
        ST_CW,
        ST_DW
    } state_t;

endpackage

FILE: hdl/bet_in_if.sv
// ----------------------------------------------------------------------------
// bet_in_if
// Request channel: the two addends and the exponent.
// ----------------------------------------------------------------------------
interface bet_in_if
    import bet_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [BASE_W-1:0] base_a;
    logic signed [BASE_W-1:0] base_b;
    logic [EXP_W-1:0]         exponent;

    modport source (output valid, output base_a, output base_b, output exponent,
                    input ready);
    modport sink (input valid, input base_a, input base_b, input exponent,
                  output ready);
endinterface

FILE: hdl/bet_out_if.sv
// ----------------------------------------------------------------------------
// bet_out_if
// Term channel: index, wrapped value, overflow flag and end-of-run mark.
// ----------------------------------------------------------------------------
interface bet_out_if
    import bet_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [EXP_W-1:0]          term_index;
    logic signed [VALUE_W-1:0] term_value;
    logic                      overflowed;
    logic                      last_term;

    modport source (output valid, output term_index, output term_value,
                    output overflowed, output last_term, input ready);
    modport sink (input valid, input term_index, input term_value,
                  input overflowed, input last_term, output ready);
endinterface

FILE: hdl/bet_mul.sv
// ----------------------------------------------------------------------------
// bet_mul
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle, giving
// the full product of a 64-bit magnitude and a 16-bit factor.
// ----------------------------------------------------------------------------
module bet_mul
    import bet_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [PROD_W-1:0] mc_reg,  mc_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [FACT_W-1:0] mp_reg,  mp_next;
    logic [MCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb
    begin
        mc_next   = mc_reg;
        acc_next  = acc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            mc_next   = {{FACT_W{1'b0}}, req.mcand};
            acc_next  = '0;
            mp_next   = req.mplier;
            cnt_next  = MCNT_W'(FACT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = mp_reg[0] ? acc_reg + mc_reg : acc_reg;
            mc_next  = {mc_reg[PROD_W-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[FACT_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        acc_reg <= acc_next;
        mp_reg  <= mp_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

FILE: hdl/bet_div.sv
// ----------------------------------------------------------------------------
// bet_div
// Restoring divider by a small divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bet_div
    import bet_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIVD_W-1:0] q_reg,    q_next;
    logic [DVSR_W-1:0] d_reg,    d_next;
    logic [DVSR_W-1:0] rem_reg,  rem_next;
    logic [DCNT_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVSR_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[DIVD_W-1]};
        if (req.start)
        begin
            q_next    = req.dividend;
            d_next    = req.divisor;
            rem_next  = '0;
            cnt_next  = DCNT_W'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = DVSR_W'(trial - {1'b0, d_reg});
                q_next   = {q_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = DVSR_W'(trial);
                q_next   = {q_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

FILE: hdl/binomial_expansion_terms.sv
// ----------------------------------------------------------------------------
// binomial_expansion_terms
// Emits the n+1 terms C(n,k)*a^(n-k)*b^k of (a+b)^n, wrapped to 64 bits, with
// an overflow flag and an end-of-run mark on each term.
// Each multiplication runs on the bit-serial multiplier, and the next binomial
// coefficient takes one such product followed by a division on the serial
// divider. One request is processed at a time. Reset returns the sequencer
// to idle and drops the output valid.
// ----------------------------------------------------------------------------
module binomial_expansion_terms
    import bet_pkg::*;
#(
    parameter logic [EXP_W-1:0] MAX_EXP = MAX_EXPONENT
)
(
    input  logic clk,
    input  logic rst_n,
    bet_in_if.sink    req,
    bet_out_if.source rsp
);

    state_t state_reg, state_next;

    logic [BASE_W-1:0]  a_mag_reg, a_mag_next;
    logic [BASE_W-1:0]  b_mag_reg, b_mag_next;
    logic               a_neg_reg, a_neg_next;
    logic               b_neg_reg, b_neg_next;
    logic [EXP_W-1:0]   n_reg, n_next;
    logic [EXP_W-1:0]   k_reg, k_next;
    logic [EXP_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] binom_reg, binom_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic               big_reg, big_next;
    logic [EXP_W-1:0]   oidx_reg, oidx_next;
    logic [VALUE_W-1:0] oval_reg, oval_next;
    logic               oovf_reg, oovf_next;
    logic               olast_reg, olast_next;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    div_req_t dreq;
    div_rsp_t drsp;

    logic [EXP_W-1:0] n_minus_k;
    logic             neg;
    logic             zero;
    logic             prod_big;
    logic             accept;

    assign n_minus_k = n_reg - k_reg;
    assign neg       = (a_neg_reg & n_minus_k[0]) ^ (b_neg_reg & k_reg[0]);
    assign zero      = ((n_minus_k != '0) && (a_mag_reg == '0))
                       || ((k_reg != '0) && (b_mag_reg == '0));
    assign prod_big  = (mrsp.product[PROD_W-1:VALUE_W] != '0)
                       || (mrsp.product[VALUE_W-1:0] > TWO_POW_63);
    assign accept    = req.valid && req.ready;

    bet_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    bet_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (req.valid) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_FA;
            ST_FA:    state_next = (cnt_reg == '0) ? ST_FB : ST_WA;
            ST_WA:    if (mrsp.done) state_next = ST_FA;
            ST_FB:    state_next = (cnt_reg == '0) ? ST_EMIT : ST_WB;
            ST_WB:    if (mrsp.done) state_next = ST_FB;
            ST_EMIT:  if (rsp.ready) state_next = (k_reg == n_reg) ? ST_IDLE : ST_CM;
            ST_CM:    state_next = ST_CW;
            ST_CW:    if (mrsp.done) state_next = ST_DW;
            ST_DW:    if (drsp.done) state_next = ST_SETUP;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready      = (state_reg == ST_IDLE);
        rsp.valid      = (state_reg == ST_EMIT);
        mreq.start     = 1'b0;
        mreq.mcand     = mag_reg;
        mreq.mplier    = a_mag_reg;
        dreq.start     = 1'b0;
        dreq.dividend  = mrsp.product[DIVD_W-1:0];
        dreq.divisor   = DVSR_W'(k_reg) + 1'b1;
        case (state_reg)
            ST_FA:   mreq.start = (cnt_reg != '0);
            ST_FB:
            begin
                mreq.start  = (cnt_reg != '0);
                mreq.mplier = b_mag_reg;
            end
            ST_CM:
            begin
                mreq.start  = 1'b1;
                mreq.mcand  = binom_reg;
                mreq.mplier = FACT_W'(n_minus_k);
            end
            ST_CW:   dreq.start = mrsp.done;
            default: ;
        endcase
    end

    always_comb
    begin
        a_mag_next = a_mag_reg;
        b_mag_next = b_mag_reg;
        a_neg_next = a_neg_reg;
        b_neg_next = b_neg_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        binom_next = binom_reg;
        mag_next   = mag_reg;
        big_next   = big_reg;
        oidx_next  = oidx_reg;
        oval_next  = oval_reg;
        oovf_next  = oovf_reg;
        olast_next = olast_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_neg_next = req.base_a[BASE_W-1];
                    b_neg_next = req.base_b[BASE_W-1];
                    a_mag_next = req.base_a[BASE_W-1] ? -req.base_a : req.base_a;
                    b_mag_next = req.base_b[BASE_W-1] ? -req.base_b : req.base_b;
                    n_next     = (req.exponent > MAX_EXP) ? MAX_EXP : req.exponent;
                    k_next     = '0;
                    binom_next = VALUE_W'(1);
                end
            end
            ST_SETUP:
            begin
                mag_next = binom_reg;
                big_next = 1'b0;
                cnt_next = n_minus_k;
            end
            ST_FA:
            begin
                if (cnt_reg == '0)
                begin
                    cnt_next = k_reg;
                end
            end
            ST_WA, ST_WB:
            begin
                if (mrsp.done)
                begin
                    mag_next = mrsp.product[VALUE_W-1:0];
                    big_next = big_reg | prod_big;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FB:
            begin
                if (cnt_reg == '0)
                begin
                    oidx_next  = k_reg;
                    oval_next  = neg ? -mag_reg : mag_reg;
                    oovf_next  = !zero
                                 && (big_reg || (!neg && (mag_reg == TWO_POW_63)));
                    olast_next = (k_reg == n_reg);
                end
            end
            ST_DW:
            begin
                if (drsp.done)
                begin
                    binom_next = drsp.quotient[VALUE_W-1:0];
                    k_next     = k_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg <= a_mag_next;
        b_mag_reg <= b_mag_next;
        a_neg_reg <= a_neg_next;
        b_neg_reg <= b_neg_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
        binom_reg <= binom_next;
        mag_reg   <= mag_next;
        big_reg   <= big_next;
        oidx_reg  <= oidx_next;
        oval_reg  <= oval_next;
        oovf_reg  <= oovf_next;
        olast_reg <= olast_next;
    end

    assign rsp.term_index = oidx_reg;
    assign rsp.term_value = oval_reg;
    assign rsp.overflowed = oovf_reg;
    assign rsp.last_term  = olast_reg;

endmodule

FILE: tb/bet_tb_if.sv
// ----------------------------------------------------------------------------
// bet_tb_if
// Testbench copies of the request and term channels are not needed; the RTL
// interfaces are used directly. This file holds the scoreboard class.
// ----------------------------------------------------------------------------
package bet_tb_pkg;
    import bet_pkg::*;

    typedef struct packed {
        logic [EXP_W-1:0]   term_index;
        logic [VALUE_W-1:0] term_value;
        logic               overflowed;
        logic               last_term;
    } term_t;

    class term_scoreboard;
        term_t pending[$];
        int    mismatches;
        int    terms_checked;
        int    requests_noted;

        // Works out every term of (a+b)^n wrapped to 64 bits, with magnitudes held in
        // 64 bits and flagged as too big once they exceed 2^63.
        function void note_request(logic [BASE_W-1:0] a_raw, logic [BASE_W-1:0] b_raw,
                                   logic [EXP_W-1:0] n_raw);
            logic [VALUE_W-1:0] a;
            logic [VALUE_W-1:0] b;
            logic [VALUE_W-1:0] a_mag;
            logic [VALUE_W-1:0] b_mag;
            logic [VALUE_W-1:0] row[64];
            logic [VALUE_W-1:0] wrapped;
            logic [VALUE_W-1:0] mag;
            logic               a_neg;
            logic               b_neg;
            logic               big;
            logic               zero;
            logic               neg;
            logic [127:0]       prod;
            int                 n;
            int                 pa;
            term_t              t;
            a = {{(VALUE_W-BASE_W){a_raw[BASE_W-1]}}, a_raw};
            b = {{(VALUE_W-BASE_W){b_raw[BASE_W-1]}}, b_raw};
            a_neg = a[VALUE_W-1];
            b_neg = b[VALUE_W-1];
            a_mag = a_neg ? -a : a;
            b_mag = b_neg ? -b : b;
            n = n_raw;
            if (n > MAX_EXPONENT)
                n = MAX_EXPONENT;
            row[0] = 1;
            for (int i = 1; i <= n; i++)
            begin
                row[i] = 1;
                for (int k = i - 1; k >= 1; k--)
                    row[k] = row[k] + row[k-1];
            end
            for (int k = 0; k <= n; k++)
            begin
                pa = n - k;
                wrapped = row[k];
                mag = row[k];
                big = 1'b0;
                zero = (pa > 0 && a_mag == 0) || (k > 0 && b_mag == 0);
                neg = (a_neg && pa[0]) != (b_neg && k[0]);
                for (int i = 0; i < n; i++)
                begin
                    wrapped = wrapped * ((i < pa) ? a : b);
                    if (!zero && !big)
                    begin
                        prod = mag * ((i < pa) ? a_mag : b_mag);
                        if (prod > {64'd0, TWO_POW_63})
                            big = 1'b1;
                        else
                            mag = prod[63:0];
                    end
                end
                t.term_index = EXP_W'(k);
                t.term_value = wrapped;
                t.overflowed = zero ? 1'b0 : big ? 1'b1 :
                               neg ? (mag > TWO_POW_63) : (mag > TWO_POW_63 - 1);
                t.last_term  = (k == n);
                pending.push_back(t);
            end
            requests_noted++;
        endfunction

        function void check_term(term_t got);
            term_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected term: index %0d value %h", got.term_index,
                             got.term_value);
                return;
            end
            want = pending.pop_front();
            terms_checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Term mismatch: expected k=%0d v=%h o=%b l=%b, got k=%0d v=%h o=%b l=%b",
                             want.term_index, want.term_value, want.overflowed,
                             want.last_term, got.term_index, got.term_value,
                             got.overflowed, got.last_term);
            end
        endfunction
    endclass
endpackage

FILE: tb/binomial_expansion_terms_tb.sv
// ----------------------------------------------------------------------------
// binomial_expansion_terms_tb
// Drives directed and random requests into the binomial expansion block with
// random idling on both channels and checks every term against a predictor.
// ----------------------------------------------------------------------------
module binomial_expansion_terms_tb;
    import bet_pkg::*;
    import bet_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    bet_in_if  req();
    bet_out_if rsp();

    term_scoreboard board;
    logic           quiet_tail;
    logic           long_hold;
    int             idle_cycles;
    int             rsp_gap;

    binomial_expansion_terms i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The request stays offered after acceptance until the next one replaces
    // it, an idle gap drops it, or release_request withdraws it.
    task automatic send_request(input logic [BASE_W-1:0] a, input logic [BASE_W-1:0] b,
                                input logic [EXP_W-1:0] n);
        int gap;
        if (!quiet_tail && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(16, 1);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.base_a   <= a;
        req.base_b   <= b;
        req.exponent <= n;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(a, b, n);
    endtask

    task automatic release_request();
        req.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        release_request();
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Small exponents keep the run short; a few requests use exponents from 40 to 63.
    task automatic send_random();
        logic [EXP_W-1:0] n;
        logic [BASE_W-1:0] a;
        logic [BASE_W-1:0] b;
        int sel;
        sel = $urandom_range(99);
        n = (sel < 2) ? EXP_W'($urandom_range(63, 40)) :
            (sel < 12) ? EXP_W'($urandom_range(20)) : EXP_W'($urandom_range(6));
        a = BASE_W'($urandom);
        b = BASE_W'($urandom);
        case ($urandom_range(7))
            0: a = '0;
            1: b = '0;
            2: a = BASE_W'($urandom_range(3) - 1);
            3: b = 16'h8000;
            default: ;
        endcase
        send_request(a, b, n);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_gap   <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                board.check_term({rsp.term_index, rsp.term_value, rsp.overflowed,
                                  rsp.last_term});
            if (long_hold)
                rsp.ready <= 1'b0;
            else if (rsp_gap > 0)
            begin
                rsp_gap   <= rsp_gap - 1;
                rsp.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(7) == 0)
            begin
                rsp_gap   <= $urandom_range(16, 1) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog expired with %0d terms pending", board.pending.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [BASE_W-1:0] edges[4];
        board        = new();
        idle_cycles  = 0;
        quiet_tail   = 1'b0;
        long_hold    = 1'b0;
        req.valid    = 1'b0;
        req.base_a   = '0;
        req.base_b   = '0;
        req.exponent = '0;
        rst_n        = 1'b0;
        edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(0, 0, 0);
        send_request(0, 5, 4);
        send_request(7, 0, 4);
        send_request(16'h0002, 16'hfffd, 63);
        send_request(1, 1, 63);
        send_request(16'h8000, 16'h8000, 5);
        send_request(16'h7fff, 16'h7fff, 8);
        send_request(16'h5555, 16'haaaa, 1);
        send_request(16'haaaa, 16'h5555, 2);
        send_request(16'hffff, 16'h0001, 63);
        send_request(16'h0001, 16'h8000, 4);
        send_request(16'h8000, 16'h0001, 4);
        send_request(16'h0003, 16'h0002, 40);
        send_request(16'h0002, 16'h0000, 63);
        send_request(16'h7fff, 16'h0000, 63);
        foreach (edges[i])
            send_request(edges[i], edges[3-i], EXP_W'(i + 1));

        // The receiver holds off while requests keep coming, so the input stalls.
        long_hold <= 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                long_hold <= 1'b0;
            end
            repeat (5) send_random();
        join
        wait_drained();
        repeat (200) @(posedge clk);

        for (int i = 0; i < 250; i++)
            send_random();
        quiet_tail <= 1'b1;
        for (int i = 0; i < 30; i++)
            send_random();

        wait_drained();
        repeat (200) @(posedge clk);
        $display("Checked %0d terms from %0d requests, including exponents 0 and 63",
                 board.terms_checked, board.requests_noted);
        $display("with zero, extreme and mixed-sign addends and stalls on both channels.");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/bet_pkg.sv
hdl/bet_in_if.sv
hdl/bet_out_if.sv
hdl/bet_mul.sv
hdl/bet_div.sv
hdl/binomial_expansion_terms.sv
tb/bet_tb_if.sv
tb/binomial_expansion_terms_tb.sv
